/* src/hsvrgb_pkg.sv */
// ---------------------------------------------------------------------------
// hsvrgb_pkg
// shared types and constants for the hsv to rgba converter pipeline
// ---------------------------------------------------------------------------
package hsvrgb_pkg;

   localparam int IN_W    = 20;
   localparam int CH_W    = 8;
   localparam int SECT_W  = 3;
   localparam int REQ_W   = 72;
   localparam int RSP_W   = 32;

   typedef enum logic [SECT_W-1:0] {
      SECT_RED_YEL = 3'd0,
      SECT_YEL_GRN = 3'd1,
      SECT_GRN_CYN = 3'd2,
      SECT_CYN_BLU = 3'd3,
      SECT_BLU_MAG = 3'd4,
      SECT_MAG_RED = 3'd5
   } sector_type;

   typedef struct packed {
      logic             valid;
      sector_type       sector;
      logic [CH_W-1:0]  alpha;
   } stage_ctl_type;

endpackage

/* src/hsvrgb_sector.sv */
// ---------------------------------------------------------------------------
// hsvrgb_sector
// first stage: hue wrap and times six, sector and fraction, input clamping
// ---------------------------------------------------------------------------
module hsvrgb_sector #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic signed [hsvrgb_pkg::IN_W-1:0] hue,
   input  logic signed [hsvrgb_pkg::IN_W-1:0] saturation,
   input  logic signed [hsvrgb_pkg::IN_W-1:0] brightness,
   input  logic [hsvrgb_pkg::CH_W-1:0]   alpha_in,
   output hsvrgb_pkg::stage_ctl_type     ctl_ff,
   output logic [FRAC_BITS:0]            sat_ff,
   output logic [FRAC_BITS:0]            bri_ff,
   output logic [FRAC_BITS-1:0]          frac_ff
);
   import hsvrgb_pkg::*;

   localparam int LVL_W = FRAC_BITS + 1;
   localparam int EXT_W = (FRAC_BITS > IN_W) ? FRAC_BITS : IN_W;
   localparam int CMP_W = EXT_W + 2;
   localparam int H6_W  = FRAC_BITS + SECT_W;
   localparam logic signed [CMP_W-1:0] ONE_C = CMP_W'(1) <<< FRAC_BITS;

   function automatic logic [LVL_W-1:0] clamp_unit(input logic signed [IN_W-1:0] x);
      logic signed [CMP_W-1:0] xe;
      xe = CMP_W'(x);
      if (xe < 0) begin
         return '0;
      end else if (xe > ONE_C) begin
         return ONE_C[LVL_W-1:0];
      end
      return xe[LVL_W-1:0];
   endfunction

   logic signed [EXT_W-1:0] hue_ext;
   logic [H6_W-1:0]         h6;
   stage_ctl_type           ctl_in;

   assign hue_ext = EXT_W'(hue);
   // times six as two shifted adds
   assign h6 = (H6_W'(hue_ext[FRAC_BITS-1:0]) << 2) + (H6_W'(hue_ext[FRAC_BITS-1:0]) << 1);

   always_comb begin
      ctl_in.valid  = in_valid;
      ctl_in.sector = sector_type'(h6[H6_W-1:FRAC_BITS]);
      ctl_in.alpha  = alpha_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff.valid <= ctl_in.valid;
      end
      if (en) begin
         ctl_ff.sector <= ctl_in.sector;
         ctl_ff.alpha  <= ctl_in.alpha;
         sat_ff        <= clamp_unit(saturation);
         bri_ff        <= clamp_unit(brightness);
         frac_ff       <= h6[FRAC_BITS-1:0];
      end
   end

endmodule

/* src/hsvrgb_mix.sv */
// ---------------------------------------------------------------------------
// hsvrgb_mix
// second stage: saturation times fraction and times its complement
// ---------------------------------------------------------------------------
module hsvrgb_mix #(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  hsvrgb_pkg::stage_ctl_type ctl_in,
   input  logic [FRAC_BITS:0]        sat_in,
   input  logic [FRAC_BITS:0]        bri_in,
   input  logic [FRAC_BITS-1:0]      frac_in,
   output hsvrgb_pkg::stage_ctl_type ctl_ff,
   output logic [FRAC_BITS:0]        sat_ff,
   output logic [FRAC_BITS:0]        bri_ff,
   output logic [FRAC_BITS:0]        sf_ff,
   output logic [FRAC_BITS:0]        sg_ff
);
   import hsvrgb_pkg::*;

   localparam int LVL_W = FRAC_BITS + 1;
   localparam int PR_W  = 2 * LVL_W;
   localparam logic [LVL_W-1:0] ONE_L = LVL_W'(1) << FRAC_BITS;

   logic [LVL_W-1:0] one_minus_f;
   logic [PR_W-1:0]  sf_prod;
   logic [PR_W-1:0]  sg_prod;

   assign one_minus_f = ONE_L - LVL_W'(frac_in);
   assign sf_prod     = PR_W'(sat_in) * PR_W'(frac_in);
   assign sg_prod     = PR_W'(sat_in) * PR_W'(one_minus_f);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff.valid <= ctl_in.valid;
      end
      if (en) begin
         ctl_ff.sector <= ctl_in.sector;
         ctl_ff.alpha  <= ctl_in.alpha;
         sat_ff        <= sat_in;
         bri_ff        <= bri_in;
         sf_ff         <= sf_prod[FRAC_BITS+LVL_W-1:FRAC_BITS];
         sg_ff         <= sg_prod[FRAC_BITS+LVL_W-1:FRAC_BITS];
      end
   end

endmodule

/* src/hsvrgb_level.sv */
// ---------------------------------------------------------------------------
// hsvrgb_level
// third stage: the p, q and t levels scaled by brightness
// ---------------------------------------------------------------------------
module hsvrgb_level #(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  hsvrgb_pkg::stage_ctl_type ctl_in,
   input  logic [FRAC_BITS:0]        sat_in,
   input  logic [FRAC_BITS:0]        bri_in,
   input  logic [FRAC_BITS:0]        sf_in,
   input  logic [FRAC_BITS:0]        sg_in,
   output hsvrgb_pkg::stage_ctl_type ctl_ff,
   output logic [FRAC_BITS:0]        bri_ff,
   output logic [FRAC_BITS:0]        p_ff,
   output logic [FRAC_BITS:0]        q_ff,
   output logic [FRAC_BITS:0]        t_ff
);
   import hsvrgb_pkg::*;

   localparam int LVL_W = FRAC_BITS + 1;
   localparam int PR_W  = 2 * LVL_W;
   localparam logic [LVL_W-1:0] ONE_L = LVL_W'(1) << FRAC_BITS;

   logic [PR_W-1:0] p_prod;
   logic [PR_W-1:0] q_prod;
   logic [PR_W-1:0] t_prod;

   assign p_prod = PR_W'(bri_in) * PR_W'(ONE_L - sat_in);
   assign q_prod = PR_W'(bri_in) * PR_W'(ONE_L - sf_in);
   assign t_prod = PR_W'(bri_in) * PR_W'(ONE_L - sg_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff.valid <= ctl_in.valid;
      end
      if (en) begin
         ctl_ff.sector <= ctl_in.sector;
         ctl_ff.alpha  <= ctl_in.alpha;
         bri_ff        <= bri_in;
         p_ff          <= p_prod[FRAC_BITS+LVL_W-1:FRAC_BITS];
         q_ff          <= q_prod[FRAC_BITS+LVL_W-1:FRAC_BITS];
         t_ff          <= t_prod[FRAC_BITS+LVL_W-1:FRAC_BITS];
      end
   end

`ifndef SYNTH
   // no level may exceed brightness
   a_p_le_b: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.valid |-> (p_ff <= bri_ff)) else $error("p above brightness");
   a_qt_le_b: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.valid |-> (q_ff <= bri_ff && t_ff <= bri_ff)) else $error("q or t above brightness");
   // p is the floor of the three levels
   a_p_floor: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.valid |-> (p_ff <= q_ff && p_ff <= t_ff)) else $error("p above q or t");
`endif

endmodule

/* src/hsvrgb_select.sv */
// ---------------------------------------------------------------------------
// hsvrgb_select
// last stage: sector routing and conversion of each level to a byte
// ---------------------------------------------------------------------------
module hsvrgb_select #(
   parameter int FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  hsvrgb_pkg::stage_ctl_type      ctl_in,
   input  logic [FRAC_BITS:0]             bri_in,
   input  logic [FRAC_BITS:0]             p_in,
   input  logic [FRAC_BITS:0]             q_in,
   input  logic [FRAC_BITS:0]             t_in,
   output logic                           valid_ff,
   output logic [hsvrgb_pkg::CH_W-1:0]    red_ff,
   output logic [hsvrgb_pkg::CH_W-1:0]    green_ff,
   output logic [hsvrgb_pkg::CH_W-1:0]    blue_ff,
   output logic [hsvrgb_pkg::CH_W-1:0]    alpha_ff
);
   import hsvrgb_pkg::*;

   localparam int LVL_W = FRAC_BITS + 1;
   localparam int SC_W  = LVL_W + CH_W;

   function automatic logic [CH_W-1:0] to_byte(input logic [LVL_W-1:0] lvl);
      logic [SC_W-1:0] scaled;
      // level times 255 as a shift and subtract
      scaled = (SC_W'(lvl) << CH_W) - SC_W'(lvl);
      return scaled[FRAC_BITS+CH_W-1:FRAC_BITS];
   endfunction

   logic [LVL_W-1:0] r_lvl;
   logic [LVL_W-1:0] g_lvl;
   logic [LVL_W-1:0] b_lvl;

   always_comb begin
      case (ctl_in.sector)
         SECT_RED_YEL: begin r_lvl = bri_in; g_lvl = t_in;   b_lvl = p_in;   end
         SECT_YEL_GRN: begin r_lvl = q_in;   g_lvl = bri_in; b_lvl = p_in;   end
         SECT_GRN_CYN: begin r_lvl = p_in;   g_lvl = bri_in; b_lvl = t_in;   end
         SECT_CYN_BLU: begin r_lvl = p_in;   g_lvl = q_in;   b_lvl = bri_in; end
         SECT_BLU_MAG: begin r_lvl = t_in;   g_lvl = p_in;   b_lvl = bri_in; end
         default:      begin r_lvl = bri_in; g_lvl = p_in;   b_lvl = q_in;   end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= ctl_in.valid;
      end
      if (en) begin
         red_ff   <= to_byte(r_lvl);
         green_ff <= to_byte(g_lvl);
         blue_ff  <= to_byte(b_lvl);
         alpha_ff <= ctl_in.alpha;
      end
   end

endmodule

/* src/hsv_to_rgb_converter_top.sv */
// ---------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// fixed-point hsv plus alpha to 8-bit rgba, four-stage pipeline
// ---------------------------------------------------------------------------
// req channel: one hsv colour and an opacity byte per word, taken when
//   req_tvalid and req_tready are both high. hue wraps to its fraction,
//   saturation and brightness are clamped to 0..1 (one = 2^FRAC_BITS).
// rsp channel: one rgba word per request word, same order.
// path: an accepted request is registered in the sector, mix and level
//   stages and then in the output register, which raises rsp_tvalid
//   (clamp and times six, saturation products, brightness products,
//   sector routing and byte scaling in the output register).
// throughput: one word per cycle unless the receiver stalls; the pipeline holds one word per stage.
// stall: while rsp_tvalid is high and rsp_tready low, every stage holds
//   and req_tready is low; nothing is dropped or repeated.
// reset: synchronous, clears all stage valid bits; the pipeline is empty
//   and ready on the first cycle after reset.
// ---------------------------------------------------------------------------
module hsv_to_rgb_converter_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // hue[19:0], saturation[39:20], brightness[59:40], alpha_in[67:60], zero pad
   input  logic [hsvrgb_pkg::REQ_W-1:0]     req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // red[7:0], green[15:8], blue[23:16], alpha_out[31:24]
   output logic [hsvrgb_pkg::RSP_W-1:0]     rsp_tdata
);
   import hsvrgb_pkg::*;

   localparam int LVL_W = FRAC_BITS + 1;

   logic                    en;
   logic signed [IN_W-1:0]  hue;
   logic signed [IN_W-1:0]  saturation;
   logic signed [IN_W-1:0]  brightness;
   logic [CH_W-1:0]         alpha_in;

   stage_ctl_type           s1_ctl;
   logic [LVL_W-1:0]        s1_sat;
   logic [LVL_W-1:0]        s1_bri;
   logic [FRAC_BITS-1:0]    s1_frac;

   stage_ctl_type           s2_ctl;
   logic [LVL_W-1:0]        s2_sat;
   logic [LVL_W-1:0]        s2_bri;
   logic [LVL_W-1:0]        s2_sf;
   logic [LVL_W-1:0]        s2_sg;

   stage_ctl_type           s3_ctl;
   logic [LVL_W-1:0]        s3_bri;
   logic [LVL_W-1:0]        s3_p;
   logic [LVL_W-1:0]        s3_q;
   logic [LVL_W-1:0]        s3_t;

   logic [CH_W-1:0]         red;
   logic [CH_W-1:0]         green;
   logic [CH_W-1:0]         blue;
   logic [CH_W-1:0]         alpha_out;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   assign hue        = $signed(req_tdata[IN_W-1:0]);
   assign saturation = $signed(req_tdata[2*IN_W-1:IN_W]);
   assign brightness = $signed(req_tdata[3*IN_W-1:2*IN_W]);
   assign alpha_in   = req_tdata[3*IN_W+CH_W-1:3*IN_W];

   hsvrgb_sector #(.FRAC_BITS(FRAC_BITS)) u_sector (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (req_tvalid),
      .hue        (hue),
      .saturation (saturation),
      .brightness (brightness),
      .alpha_in   (alpha_in),
      .ctl_ff     (s1_ctl),
      .sat_ff     (s1_sat),
      .bri_ff     (s1_bri),
      .frac_ff    (s1_frac)
   );

   hsvrgb_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .ctl_in  (s1_ctl),
      .sat_in  (s1_sat),
      .bri_in  (s1_bri),
      .frac_in (s1_frac),
      .ctl_ff  (s2_ctl),
      .sat_ff  (s2_sat),
      .bri_ff  (s2_bri),
      .sf_ff   (s2_sf),
      .sg_ff   (s2_sg)
   );

   hsvrgb_level #(.FRAC_BITS(FRAC_BITS)) u_level (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .ctl_in (s2_ctl),
      .sat_in (s2_sat),
      .bri_in (s2_bri),
      .sf_in  (s2_sf),
      .sg_in  (s2_sg),
      .ctl_ff (s3_ctl),
      .bri_ff (s3_bri),
      .p_ff   (s3_p),
      .q_ff   (s3_q),
      .t_ff   (s3_t)
   );

   hsvrgb_select #(.FRAC_BITS(FRAC_BITS)) u_select (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .ctl_in   (s3_ctl),
      .bri_in   (s3_bri),
      .p_in     (s3_p),
      .q_in     (s3_q),
      .t_in     (s3_t),
      .valid_ff (rsp_tvalid),
      .red_ff   (red),
      .green_ff (green),
      .blue_ff  (blue),
      .alpha_ff (alpha_out)
   );

   assign rsp_tdata = {alpha_out, blue, green, red};

`ifndef SYNTH
   // a held pipeline keeps its occupancy
   a_hold_occupancy: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable({s1_ctl.valid, s2_ctl.valid, s3_ctl.valid, rsp_tvalid}))
      else $error("stage valid changed during stall");
`endif

endmodule
